// File: hw/rtl/bpc_pkg.sv
// shared types and constants of the binary pixel centroid unit
// no dependencies; used by bpc_accum, bpc_divider and binary_pixel_centroid_unit

package bpc_pkg;

   // payload and state widths
   localparam int PixelWidth    = 8;
   localparam int ColWidth      = 11;
   localparam int RowWidth      = 11;
   localparam int SumWidth      = 33;
   localparam int CountWidth    = 23;
   localparam int QuoWidth      = 11;
   localparam int RowWidthBits  = 12;
   localparam int DivCountWidth = $clog2(QuoWidth);

   // configuration port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // image size limits
   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 2048;
   localparam int ColLimit  = 2048;
   localparam int RowLimit  = 2048;

   localparam int WidthCap  = (MaxWidth > ColLimit) ? ColLimit : MaxWidth;
   localparam int WidthLim  = (WidthCap < 1) ? 1 : WidthCap;
   localparam int HeightCap = (MaxHeight > RowLimit) ? RowLimit : MaxHeight;
   localparam int HeightLim = (HeightCap < 1) ? 1 : HeightCap;

   localparam logic [RowWidthBits-1:0] WidthMax = RowWidthBits'(WidthLim);
   localparam logic [RowWidth-1:0]     LastRow  = RowWidth'(HeightLim - 1);

   // register reset values
   localparam logic [RowWidthBits-1:0] RowWidthReset   = 12'd640;
   localparam logic [PixelWidth-1:0]   MatchValueReset = 8'hff;

   // register indexes
   localparam logic RegRowWidth   = 1'b0;
   localparam logic RegMatchValue = 1'b1;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_PREP,
      ST_DIV_X,
      ST_DIV_Y,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic step;     // pixel word accepted
      logic advance;  // move to the next pixel position
      logic clear;    // frame finished, clear sums and position
   } accum_ctrl_type;

endpackage

// File: hw/rtl/binary_pixel_centroid_unit.sv
// top level of the binary pixel centroid unit: csr block, sequencer, output register
// depends on bpc_pkg, bpc_accum and bpc_divider

// Takes one 8-bit pixel word per clock in raster order and tracks column and
// row itself, wrapping the column at row_width (0 acts as 1, values above 2048
// act as 2048; the row saturates at 2047). Pixels equal to match_value add
// their position to running sums. The pixel word flagged frame_end is counted,
// then the unit stops taking words while one shared 11-step restoring divider
// computes the x and then the y centroid: a frame end word passes through its
// accept, a setup state, the x and y divisions and a load state, and the
// divisions are skipped when nothing matched. Every other pixel word is taken at
// one per clock. The result word waits in an output register, so pixel words
// keep flowing while it is held; a following frame end only waits for that
// register to drain.
// Registers: row_width at byte address 0, match_value at byte address 4.

module binary_pixel_centroid_unit (
   input  logic                                clock,
   input  logic                                reset,
   // pixel words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpc_pkg::PixelWidth-1:0]      req_pixel,
   input  logic                                req_frame_end,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpc_pkg::QuoWidth-1:0]        rsp_centroid_x,
   output logic [bpc_pkg::QuoWidth-1:0]        rsp_centroid_y,
   output logic [bpc_pkg::CountWidth-1:0]      rsp_match_count,
   output logic                                rsp_no_match,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [bpc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [bpc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // configuration registers
   logic [bpc_pkg::RowWidthBits-1:0] row_width_ff, row_width_in;
   logic [bpc_pkg::PixelWidth-1:0]   match_value_ff, match_value_in;
   logic                             csr_write;
   logic                             csr_index;

   // sequencer
   bpc_pkg::state_type               state_ff, state_in;
   bpc_pkg::accum_ctrl_type          accum_ctrl;
   logic                             req_accept;

   // accumulator outputs
   logic [bpc_pkg::SumWidth-1:0]     sum_columns;
   logic [bpc_pkg::SumWidth-1:0]     sum_rows;
   logic [bpc_pkg::CountWidth-1:0]   hit_count;

   // shared divider
   logic                             div_start;
   logic                             div_sel_y;
   logic [bpc_pkg::SumWidth-1:0]     div_dividend;
   logic                             div_done;
   logic [bpc_pkg::QuoWidth-1:0]     div_quotient;

   // centroid holding and output registers
   logic [bpc_pkg::QuoWidth-1:0]     cx_ff, cx_in;
   logic [bpc_pkg::QuoWidth-1:0]     cy_ff, cy_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bpc_pkg::QuoWidth-1:0]     rsp_cx_ff, rsp_cx_in;
   logic [bpc_pkg::QuoWidth-1:0]     rsp_cy_ff, rsp_cy_in;
   logic [bpc_pkg::CountWidth-1:0]   rsp_count_ff, rsp_count_in;
   logic                             rsp_none_ff, rsp_none_in;
   logic                             load;

   // register port, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      row_width_in   = row_width_ff;
      match_value_in = match_value_ff;
      if (csr_write) begin
         case (csr_index)
            bpc_pkg::RegRowWidth: begin
               row_width_in = csr_pwdata[bpc_pkg::RowWidthBits-1:0];
            end
            bpc_pkg::RegMatchValue: begin
               match_value_in = csr_pwdata[bpc_pkg::PixelWidth-1:0];
            end
            default: begin
               row_width_in = row_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bpc_pkg::RegRowWidth: begin
            csr_prdata = bpc_pkg::CsrDataWidth'(row_width_ff);
         end
         bpc_pkg::RegMatchValue: begin
            csr_prdata = bpc_pkg::CsrDataWidth'(match_value_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= bpc_pkg::RowWidthReset;
         match_value_ff <= bpc_pkg::MatchValueReset;
      end else begin
         row_width_ff   <= row_width_in;
         match_value_ff <= match_value_in;
      end
   end

   // pixel words only while accumulating
   assign req_ready  = (state_ff == bpc_pkg::ST_ACCUM);
   assign req_accept = req_valid && req_ready;

   // output register frees when empty or being taken this cycle
   assign load = (state_ff == bpc_pkg::ST_LOAD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in           = state_ff;
      accum_ctrl.step    = req_accept;
      accum_ctrl.advance = req_accept && !req_frame_end;
      accum_ctrl.clear   = load;
      div_start          = 1'b0;
      div_sel_y          = 1'b0;
      cx_in              = cx_ff;
      cy_in              = cy_ff;
      case (state_ff)
         bpc_pkg::ST_ACCUM: begin
            if (req_accept && req_frame_end) begin
               state_in = bpc_pkg::ST_PREP;
            end
         end
         bpc_pkg::ST_PREP: begin
            // empty frame: centroids are zero, no division
            if (hit_count == '0) begin
               cx_in    = '0;
               cy_in    = '0;
               state_in = bpc_pkg::ST_LOAD;
            end else begin
               div_start = 1'b1;
               state_in  = bpc_pkg::ST_DIV_X;
            end
         end
         bpc_pkg::ST_DIV_X: begin
            if (div_done) begin
               cx_in     = div_quotient;
               div_start = 1'b1;
               div_sel_y = 1'b1;
               state_in  = bpc_pkg::ST_DIV_Y;
            end
         end
         bpc_pkg::ST_DIV_Y: begin
            if (div_done) begin
               cy_in    = div_quotient;
               state_in = bpc_pkg::ST_LOAD;
            end
         end
         bpc_pkg::ST_LOAD: begin
            if (load) begin
               state_in = bpc_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = bpc_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpc_pkg::ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   assign div_dividend = div_sel_y ? sum_rows : sum_columns;

   bpc_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (accum_ctrl),
      .pixel       (req_pixel),
      .match_value (match_value_ff),
      .row_width   (row_width_ff),
      .sum_columns (sum_columns),
      .sum_rows    (sum_rows),
      .hit_count   (hit_count)
   );

   bpc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (hit_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_count_in = rsp_count_ff;
      rsp_none_in  = rsp_none_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_cx_in    = cx_ff;
         rsp_cy_in    = cy_ff;
         rsp_count_in = hit_count;
         rsp_none_in  = (hit_count == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
      rsp_count_ff <= rsp_count_in;
      rsp_none_ff  <= rsp_none_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centroid_x  = rsp_cx_ff;
   assign rsp_centroid_y  = rsp_cy_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_no_match    = rsp_none_ff;

endmodule

// File: hw/rtl/bpc_accum.sv
// pixel position tracking and running sums of matching pixels
// depends on bpc_pkg

module bpc_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bpc_pkg::accum_ctrl_type              ctrl,
   input  logic [bpc_pkg::PixelWidth-1:0]       pixel,
   input  logic [bpc_pkg::PixelWidth-1:0]       match_value,
   input  logic [bpc_pkg::RowWidthBits-1:0]     row_width,
   output logic [bpc_pkg::SumWidth-1:0]         sum_columns,
   output logic [bpc_pkg::SumWidth-1:0]         sum_rows,
   output logic [bpc_pkg::CountWidth-1:0]       hit_count
);

   logic [bpc_pkg::ColWidth-1:0]     column_ff, column_in;
   logic [bpc_pkg::RowWidth-1:0]     row_ff, row_in;
   logic [bpc_pkg::SumWidth-1:0]     sum_col_ff, sum_col_in;
   logic [bpc_pkg::SumWidth-1:0]     sum_row_ff, sum_row_in;
   logic [bpc_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [bpc_pkg::RowWidthBits-1:0] width_eff;
   logic [bpc_pkg::RowWidthBits-1:0] column_next;
   logic                             hit;

   always_comb begin
      if (row_width == '0) begin
         width_eff = bpc_pkg::RowWidthBits'(1);
      end else if (row_width > bpc_pkg::WidthMax) begin
         width_eff = bpc_pkg::WidthMax;
      end else begin
         width_eff = row_width;
      end
   end

   assign column_next = {1'b0, column_ff} + bpc_pkg::RowWidthBits'(1);
   // count saturates at the top bit of the counter
   assign hit = ctrl.step && (pixel == match_value) && !count_ff[bpc_pkg::CountWidth-1];

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      sum_col_in = sum_col_ff;
      sum_row_in = sum_row_ff;
      count_in   = count_ff;
      if (ctrl.clear) begin
         column_in  = '0;
         row_in     = '0;
         sum_col_in = '0;
         sum_row_in = '0;
         count_in   = '0;
      end else begin
         if (hit) begin
            sum_col_in = sum_col_ff + bpc_pkg::SumWidth'(column_ff);
            sum_row_in = sum_row_ff + bpc_pkg::SumWidth'(row_ff);
            count_in   = count_ff + bpc_pkg::CountWidth'(1);
         end
         if (ctrl.advance) begin
            if (column_next >= width_eff) begin
               column_in = '0;
               if (row_ff < bpc_pkg::LastRow) begin
                  row_in = row_ff + bpc_pkg::RowWidth'(1);
               end
            end else begin
               column_in = column_next[bpc_pkg::ColWidth-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         sum_col_ff <= '0;
         sum_row_ff <= '0;
         count_ff   <= '0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         sum_col_ff <= sum_col_in;
         sum_row_ff <= sum_row_in;
         count_ff   <= count_in;
      end
   end

   assign sum_columns = sum_col_ff;
   assign sum_rows    = sum_row_ff;
   assign hit_count   = count_ff;

endmodule

// File: hw/rtl/bpc_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on bpc_pkg; the quotient is known to fit QuoWidth bits

module bpc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bpc_pkg::SumWidth-1:0]      dividend,
   input  logic [bpc_pkg::CountWidth-1:0]    divisor,
   output logic                              done,
   output logic [bpc_pkg::QuoWidth-1:0]      quotient
);

   localparam int RemWidth = bpc_pkg::CountWidth;
   localparam logic [bpc_pkg::DivCountWidth-1:0] LastStep =
      bpc_pkg::DivCountWidth'(bpc_pkg::QuoWidth - 1);

   logic [RemWidth-1:0]                rem_ff, rem_in;
   logic [bpc_pkg::QuoWidth-1:0]       quo_ff, quo_in;
   logic [bpc_pkg::DivCountWidth-1:0]  count_ff, count_in;
   logic [bpc_pkg::CountWidth-1:0]     divisor_ff, divisor_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [RemWidth:0]                  trial;
   logic [RemWidth:0]                  diff;
   logic                               take;

   // partial remainder stays below the divisor, so one extra bit holds the trial
   assign trial = {rem_ff, quo_ff[bpc_pkg::QuoWidth-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign take  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         // upper dividend bits are already below the divisor
         rem_in     = RemWidth'(dividend[bpc_pkg::SumWidth-1:bpc_pkg::QuoWidth]);
         quo_in     = dividend[bpc_pkg::QuoWidth-1:0];
         divisor_in = divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = take ? diff[RemWidth-1:0] : trial[RemWidth-1:0];
         quo_in   = {quo_ff[bpc_pkg::QuoWidth-2:0], take};
         count_in = count_ff + bpc_pkg::DivCountWidth'(1);
         if (count_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
